FILE: design/gbt_pkg.sv
// ----------------------------------------------------------------------------
// gbt_pkg
// shared types and constants of the graph traversal block
// ----------------------------------------------------------------------------
package gbt_pkg;

  localparam int unsigned MaxVertices = 8;
  localparam int unsigned VtxW        = $clog2(MaxVertices);
  localparam int unsigned CntW        = $clog2(MaxVertices + 1);
  localparam int unsigned WeightW     = 20;
  localparam int unsigned VcountW     = 4;

  localparam logic [WeightW-1:0] InfWeight  = WeightW'(1000000);
  localparam logic [CntW-1:0]    ScanFull   = CntW'(MaxVertices);
  localparam logic [VcountW-1:0] VcountMax  = VcountW'(MaxVertices);
  localparam logic [VcountW-1:0] VcountRst  = VcountW'(8);

  typedef enum logic [1:0] {
    CmdClear = 2'd0,
    CmdLoad  = 2'd1,
    CmdBfs   = 2'd2,
    CmdDfs   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StDrain
  } walk_state_e;

  // write request to the adjacency store
  typedef struct packed {
    logic               clear;
    logic               load;
    logic [VtxW-1:0]    row;
    logic [VtxW-1:0]    col;
    logic [WeightW-1:0] weight;
  } adj_req_t;

  // start request to the walk sequencer
  typedef struct packed {
    logic            start;
    logic            depth;
    logic [VtxW-1:0] vertex;
  } walk_req_t;

  // one visited vertex on its way out
  typedef struct packed {
    logic            valid;
    logic [VtxW-1:0] vertex;
    logic            last;
  } out_item_t;

endpackage

FILE: design/gbt_adj.sv
// ----------------------------------------------------------------------------
// gbt_adj
// adjacency bit matrix with vertex count register and row read port
// ----------------------------------------------------------------------------
module gbt_adj (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [gbt_pkg::VcountW-1:0]           cfg_wdata_i,
  input  gbt_pkg::adj_req_t                     req_i,
  input  logic [gbt_pkg::VtxW-1:0]              rd_row_i,
  output logic [gbt_pkg::MaxVertices-1:0]       rd_data_o
);

  logic [gbt_pkg::MaxVertices-1:0] adj_q [gbt_pkg::MaxVertices];
  logic [gbt_pkg::VcountW-1:0]     vcount_q;
  logic [gbt_pkg::VcountW-1:0]     n_eff;
  logic                            edge_ok;

  // counts above the matrix size saturate
  assign n_eff = (vcount_q > gbt_pkg::VcountMax) ? gbt_pkg::VcountMax : vcount_q;

  assign edge_ok = (gbt_pkg::VcountW'(req_i.row) < n_eff)
                && (gbt_pkg::VcountW'(req_i.col) < n_eff)
                && (req_i.weight != '0)
                && (req_i.weight != gbt_pkg::InfWeight);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= gbt_pkg::VcountRst;
    end else if (cfg_we_i) begin
      vcount_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < gbt_pkg::MaxVertices; i++) adj_q[i] <= '0;
    end else if (req_i.clear) begin
      for (int i = 0; i < gbt_pkg::MaxVertices; i++) adj_q[i] <= '0;
    end else if (req_i.load && edge_ok) begin
      adj_q[req_i.row][req_i.col] <= 1'b1;
    end
  end

  assign rd_data_o = adj_q[rd_row_i];

endmodule

FILE: design/gbt_walk.sv
// ----------------------------------------------------------------------------
// gbt_walk
// walk sequencer: one neighbour test per cycle, queue or stack, then drain
// ----------------------------------------------------------------------------
module gbt_walk (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  gbt_pkg::walk_req_t                req_i,
  output logic                              idle_o,
  output logic [gbt_pkg::VtxW-1:0]          row_sel_o,
  input  logic [gbt_pkg::MaxVertices-1:0]   row_i,
  output gbt_pkg::out_item_t                out_o,
  input  logic                              out_ready_i
);

  localparam int unsigned VtxW = gbt_pkg::VtxW;
  localparam int unsigned CntW = gbt_pkg::CntW;
  localparam int unsigned Nv   = gbt_pkg::MaxVertices;

  gbt_pkg::walk_state_e state_q, state_d;

  logic [Nv-1:0]   visited_q;
  logic [VtxW-1:0] order_q   [Nv];   // visit order, doubles as the fifo
  logic [VtxW-1:0] stk_node_q[Nv];
  logic [CntW-1:0] stk_scan_q[Nv];
  logic [CntW-1:0] cnt_q;
  logic [CntW-1:0] head_q;
  logic [CntW-1:0] out_idx_q;
  logic [CntW-1:0] scan_q;
  logic [VtxW-1:0] sp_q;
  logic [VtxW-1:0] cur_q;
  logic            depth_q;

  logic [VtxW-1:0] col;
  logic            hit;
  logic            scan_done;
  logic [VtxW-1:0] ord_idx;
  logic [VtxW-1:0] ord_rd;
  logic [VtxW-1:0] stk_top;
  logic            walk_done;
  logic            drain_done;

  // shared test unit: edge present and target not yet seen
  assign col       = scan_q[VtxW-1:0] - VtxW'(1);
  assign row_sel_o = cur_q;
  assign hit       = row_i[col] & ~visited_q[col];
  assign scan_done = (scan_q == '0);

  assign ord_idx = (state_q == gbt_pkg::StDrain) ? out_idx_q[VtxW-1:0] : head_q[VtxW-1:0];
  assign ord_rd  = order_q[ord_idx];
  assign stk_top = sp_q - VtxW'(1);

  assign walk_done  = scan_done && (depth_q ? (sp_q == '0) : (head_q == cnt_q));
  assign drain_done = (out_idx_q == cnt_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gbt_pkg::StIdle:  if (req_i.start) state_d = gbt_pkg::StScan;
      gbt_pkg::StScan:  if (walk_done) state_d = gbt_pkg::StDrain;
      gbt_pkg::StDrain: if (drain_done) state_d = gbt_pkg::StIdle;
      default:          state_d = gbt_pkg::StIdle;
    endcase
  end

  always_comb begin
    idle_o       = 1'b0;
    out_o.valid  = 1'b0;
    out_o.vertex = ord_rd;
    out_o.last   = (out_idx_q == (cnt_q - CntW'(1)));
    unique case (state_q)
      gbt_pkg::StIdle:  idle_o = 1'b1;
      gbt_pkg::StScan:  idle_o = 1'b0;
      gbt_pkg::StDrain: out_o.valid = !drain_done;
      default:          idle_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gbt_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // control counters and visited map
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      visited_q <= '0;
      cnt_q     <= '0;
      head_q    <= '0;
      out_idx_q <= '0;
      scan_q    <= '0;
      sp_q      <= '0;
      depth_q   <= 1'b0;
    end else begin
      unique case (state_q)
        gbt_pkg::StIdle: begin
          if (req_i.start) begin
            visited_q <= Nv'(1) << req_i.vertex;
            cnt_q     <= CntW'(1);
            head_q    <= CntW'(1);
            out_idx_q <= '0;
            scan_q    <= gbt_pkg::ScanFull;
            sp_q      <= '0;
            depth_q   <= req_i.depth;
          end
        end
        gbt_pkg::StScan: begin
          if (!scan_done) begin
            if (hit) begin
              visited_q[col] <= 1'b1;
              cnt_q          <= cnt_q + CntW'(1);
            end
            // a depth-first hit descends into a fresh full scan
            if (hit && depth_q) begin
              sp_q   <= sp_q + VtxW'(1);
              scan_q <= gbt_pkg::ScanFull;
            end else begin
              scan_q <= scan_q - CntW'(1);
            end
          end else if (depth_q) begin
            if (sp_q != '0) begin
              sp_q   <= stk_top;
              scan_q <= stk_scan_q[stk_top];
            end
          end else if (head_q != cnt_q) begin
            head_q <= head_q + CntW'(1);
            scan_q <= gbt_pkg::ScanFull;
          end
        end
        gbt_pkg::StDrain: begin
          if (out_ready_i && !drain_done) out_idx_q <= out_idx_q + CntW'(1);
        end
        default: ;
      endcase
    end
  end

  // payload: current vertex, visit order and descent stack
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      gbt_pkg::StIdle: begin
        if (req_i.start) begin
          cur_q      <= req_i.vertex;
          order_q[0] <= req_i.vertex;
        end
      end
      gbt_pkg::StScan: begin
        if (!scan_done) begin
          if (hit) begin
            order_q[cnt_q[VtxW-1:0]] <= col;
            if (depth_q) begin
              stk_node_q[sp_q] <= cur_q;
              stk_scan_q[sp_q] <= scan_q - CntW'(1);
              cur_q            <= col;
            end
          end
        end else if (depth_q) begin
          if (sp_q != '0) cur_q <= stk_node_q[stk_top];
        end else if (head_q != cnt_q) begin
          cur_q <= ord_rd;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: design/graph_bfs_dfs_traversal.sv
// ----------------------------------------------------------------------------
// graph_bfs_dfs_traversal
// adjacency matrix graph with breadth-first and depth-first walks
// ----------------------------------------------------------------------------
// usage
//   input stream: tuser carries the command (clear, load entry, breadth-first
//   walk, depth-first walk), tdata the entry row, column, weight and the
//   walk start vertex. output stream: one item per visited vertex in visit
//   order, tlast on the final vertex of the walk.
//   cfg_we_i writes vertex_count (loads at or beyond it are dropped); write it
//   only while the block is idle.
// timing
//   clear and load items are taken one per cycle, back to back, while the
//   block is idle. a walk holds s_axis_tready low from the cycle after it is
//   taken: the scan loop gives each visited vertex eight single-column tests
//   plus one queue or stack pop, then the visit order drains one vertex per
//   cycle while the receiver keeps up, and the walk returns to idle. the scan
//   rate is set by the one shared neighbour-test unit.
// reset: asynchronous active low: no edges, vertex_count 8, walk idle, output empty.
// stall: a stalled receiver holds the output register and pauses the drain; a
//   new item is taken once the walk is back to idle, even with the last one waiting.
// ----------------------------------------------------------------------------
module graph_bfs_dfs_traversal (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,     // vertex_count
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,    // row[2:0], col[5:3], weight[25:6], start_vertex[28:26]
  input  logic [1:0]  s_axis_tuser,    // command[1:0]
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,    // vertex[2:0]
  output logic        m_axis_tlast     // last
);

  localparam int unsigned VtxW = gbt_pkg::VtxW;

  gbt_pkg::cmd_e       cmd;
  gbt_pkg::adj_req_t   adj_req;
  gbt_pkg::walk_req_t  walk_req;
  gbt_pkg::out_item_t  walk_out;
  logic                s_accept;
  logic                walk_idle;
  logic                out_ready;
  logic [VtxW-1:0]     row_sel;
  logic [gbt_pkg::MaxVertices-1:0] row_data;

  logic                m_valid_q;
  logic [VtxW-1:0]     m_vertex_q;
  logic                m_last_q;

  assign cmd           = gbt_pkg::cmd_e'(s_axis_tuser);
  assign s_axis_tready = walk_idle;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // unpack the input item
  always_comb begin
    adj_req.clear   = 1'b0;
    adj_req.load    = 1'b0;
    adj_req.row     = s_axis_tdata[2:0];
    adj_req.col     = s_axis_tdata[5:3];
    adj_req.weight  = s_axis_tdata[25:6];
    walk_req.start  = 1'b0;
    walk_req.depth  = 1'b0;
    walk_req.vertex = s_axis_tdata[28:26];
    if (s_accept) begin
      unique case (cmd)
        gbt_pkg::CmdClear: adj_req.clear = 1'b1;
        gbt_pkg::CmdLoad:  adj_req.load  = 1'b1;
        gbt_pkg::CmdBfs:   walk_req.start = 1'b1;
        gbt_pkg::CmdDfs: begin
          walk_req.start = 1'b1;
          walk_req.depth = 1'b1;
        end
        default: ;
      endcase
    end
  end

  gbt_adj u_adj (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (adj_req),
    .rd_row_i    (row_sel),
    .rd_data_o   (row_data)
  );

  gbt_walk u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (walk_req),
    .idle_o      (walk_idle),
    .row_sel_o   (row_sel),
    .row_i       (row_data),
    .out_o       (walk_out),
    .out_ready_i (out_ready)
  );

  // output register: refills when empty or when its item is taken
  assign out_ready = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_ready) begin
      m_valid_q <= walk_out.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && walk_out.valid) begin
      m_vertex_q <= walk_out.vertex;
      m_last_q   <= walk_out.last;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(8 - VtxW){1'b0}}, m_vertex_q};
  assign m_axis_tlast  = m_last_q;

`ifndef SYNTHESIS
  // a walk item closes the input until the walk has drained
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && s_axis_tuser[1]) |=> !s_axis_tready)
    else $error("input still open after a walk item");

  // after a clear or load item the input stays open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && !s_axis_tuser[1]) |=> s_axis_tready)
    else $error("input closed after a clear or load item");

  // a waiting output item holds still until it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("output item changed while stalled");
`endif

endmodule

FILE: sim/gbt_visit_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gbt_visit_checker
// tracks the graph from the accepted items, works out the visit order of
// every walk and compares it with the output stream in order
// ----------------------------------------------------------------------------
module gbt_visit_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,    // row[2:0], col[5:3], weight[25:6], start_vertex[28:26]
  input  logic [1:0]  s_axis_tuser,    // command[1:0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,    // vertex[2:0]
  input  logic        m_axis_tlast,
  output int          fail_count_o,
  output int          pending_o,
  output int          walk_count_o,
  output int          visit_count_o
);

  localparam int unsigned VtxW     = gbt_pkg::VtxW;
  localparam int unsigned Nv       = gbt_pkg::MaxVertices;
  localparam int          ExpDepth = 256;

  typedef struct packed {
    logic [VtxW-1:0] vertex;
    logic            last;
  } visit_t;

  logic [Nv-1:0]               adj_rows [Nv];
  logic [gbt_pkg::VcountW-1:0] vertex_count;
  visit_t                      exp_mem [ExpDepth];   // ring of predicted visits
  int                          exp_wr;
  int                          exp_rd;
  logic [VtxW-1:0]             walk_seq [Nv];
  int                          walk_len;
  int                          errors;
  int                          walks;
  int                          visits;

  gbt_pkg::cmd_e               cmd;
  logic [VtxW-1:0]             row;
  logic [VtxW-1:0]             col;
  logic [gbt_pkg::WeightW-1:0] weight;
  logic [VtxW-1:0]             start;
  int                          lim;
  visit_t                      got;
  visit_t                      want;

  // visit order of one walk into walk_seq, neighbours from the top index down
  task automatic trace_walk(input logic depth_first, input logic [VtxW-1:0] root);
    logic [Nv-1:0]   seen;
    logic [VtxW-1:0] fifo [Nv];
    logic [VtxW-1:0] path_node [Nv];
    int              path_scan [Nv];
    int              head;
    int              tail;
    int              sp;
    int              c;
    walk_len   = 0;
    seen       = '0;
    seen[root] = 1'b1;
    walk_seq[walk_len] = root;
    walk_len++;
    if (!depth_first) begin
      fifo[0] = root;
      head    = 0;
      tail    = 1;
      while (head < tail) begin
        for (c = Nv - 1; c >= 0; c--) begin
          if (adj_rows[fifo[head]][c] && !seen[c]) begin
            seen[c] = 1'b1;
            walk_seq[walk_len] = VtxW'(c);
            walk_len++;
            fifo[tail] = VtxW'(c);
            tail++;
          end
        end
        head++;
      end
    end else begin
      path_node[0] = root;
      path_scan[0] = Nv;
      sp           = 1;
      while (sp > 0) begin
        if (path_scan[sp-1] == 0) begin
          sp--;
        end else begin
          path_scan[sp-1]--;
          c = path_scan[sp-1];
          if (adj_rows[path_node[sp-1]][c] && !seen[c]) begin
            seen[c] = 1'b1;
            walk_seq[walk_len] = VtxW'(c);
            walk_len++;
            path_node[sp] = VtxW'(c);
            path_scan[sp] = Nv;
            sp++;
          end
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Nv; i++) adj_rows[i] = '0;
      vertex_count = gbt_pkg::VcountRst;
      exp_wr        = 0;
      exp_rd        = 0;
      walk_len      = 0;
      errors        = 0;
      walks         = 0;
      visits        = 0;
      fail_count_o  <= 0;
      pending_o     <= 0;
      walk_count_o  <= 0;
      visit_count_o <= 0;
    end else begin
      if (cfg_we_i) vertex_count = cfg_wdata_i;

      if (s_axis_tvalid && s_axis_tready) begin
        cmd    = gbt_pkg::cmd_e'(s_axis_tuser);
        row    = s_axis_tdata[2:0];
        col    = s_axis_tdata[5:3];
        weight = s_axis_tdata[25:6];
        start  = s_axis_tdata[28:26];
        case (cmd)
          gbt_pkg::CmdClear: begin
            for (int i = 0; i < Nv; i++) adj_rows[i] = '0;
          end
          gbt_pkg::CmdLoad: begin
            lim = (vertex_count > gbt_pkg::VcountMax) ? Nv : int'(vertex_count);
            if (row < lim && col < lim && weight != '0 && weight != gbt_pkg::InfWeight)
              adj_rows[row][col] = 1'b1;
          end
          default: begin
            trace_walk(cmd == gbt_pkg::CmdDfs, start);
            for (int i = 0; i < walk_len; i++) begin
              if (exp_wr - exp_rd >= ExpDepth) begin
                $error("prediction ring overflow");
                errors++;
              end
              exp_mem[exp_wr % ExpDepth] = '{vertex: walk_seq[i],
                                             last: (i == walk_len - 1)};
              exp_wr++;
            end
            walks++;
          end
        endcase
      end

      if (m_axis_tvalid && m_axis_tready) begin
        got.vertex = m_axis_tdata[2:0];
        got.last   = m_axis_tlast;
        visits++;
        if (exp_wr == exp_rd) begin
          $error("unexpected result: vertex %0d last %0b", got.vertex, got.last);
          errors++;
        end else begin
          want = exp_mem[exp_rd % ExpDepth];
          exp_rd++;
          if (got.vertex !== want.vertex) begin
            $error("vertex: expected %0d, actual %0d", want.vertex, got.vertex);
            errors++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, got.last);
            errors++;
          end
          if (m_axis_tdata[7:3] !== '0) begin
            $error("tdata padding: expected 0, actual %0h", m_axis_tdata[7:3]);
            errors++;
          end
        end
      end

      fail_count_o  <= errors;
      pending_o     <= exp_wr - exp_rd;
      walk_count_o  <= walks;
      visit_count_o <= visits;
    end
  end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// graph traversal block: directed graphs first, then random load and walk
// traffic under several vertex_count settings, with bursty input, a stalling
// receiver and one long receiver hold-off; a checker predicts every walk
// ----------------------------------------------------------------------------
module testbench;

  localparam int HoldOffCycles = 400;      // long receiver hold-off
  localparam int SettleCycles  = 8;        // lets loads and clears settle
  localparam int DrainCycles   = 100;      // settle time at the end of the run
  localparam int TimeoutNs     = 5000000;  // many times the slowest correct run
  localparam int PhaseItems    = 37;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [3:0]  cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;

  int fail_count;
  int pending;
  int walk_count;
  int visit_count;

  // stimulus bookkeeping
  int          burst_left = 0;
  int          items_sent = 0;
  int          settings_written = 0;
  logic [3:0]  cur_vcount = gbt_pkg::VcountRst;
  logic        hold_off_req = 1'b0;
  int          rx_cyc = 0;
  int          rx_mode = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  graph_bfs_dfs_traversal dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  gbt_visit_checker visit_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .walk_count_o  (walk_count),
    .visit_count_o (visit_count)
  );

  // offer one item and hold it until taken; the sender works in bursts and
  // drops valid for a random gap between them, so valid
  // is never lowered and raised in the same step
  task automatic send_item(input gbt_pkg::cmd_e cmd, input logic [2:0] row,
                           input logic [2:0] col, input logic [19:0] weight,
                           input logic [2:0] start);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {3'b000, start, weight, col, row};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    burst_left--;
    items_sent++;
  endtask

  task automatic load_entry(input logic [2:0] row, input logic [2:0] col,
                            input logic [19:0] weight);
    send_item(gbt_pkg::CmdLoad, row, col, weight, 3'd0);
  endtask

  task automatic walk_from(input gbt_pkg::cmd_e cmd, input logic [2:0] start);
    send_item(cmd, 3'd0, 3'd0, 20'd0, start);
  endtask

  // stop offering, wait until every predicted vertex has come out, then let
  // a load still in flight settle; it waits on the clock first so the
  // checker's count already includes the last item taken
  task automatic wait_drained(input int settle);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // only called with the block idle
  task automatic write_vertex_count(input logic [3:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_vcount = value;
    settings_written++;
  endtask

  // receiver: a stall pattern of its own, re-chosen as rx_cyc steps on, plus one
  // long hold-off on request, counted here in cycles
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        if (rx_cyc % 48 == 0) rx_mode = $urandom_range(0, 3);
        rx_cyc++;
        case (rx_mode)
          0:       m_axis_tready <= 1'b1;                       // no stalls at all
          1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
          2:       m_axis_tready <= (rx_cyc % 4 == 0);          // ready only when rx_cyc is a multiple of 4
          default: m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin
    #(TimeoutNs);
    $display("timeout: block stopped making progress");
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int            phase_vcount [7];
    int            pick;
    int            lim;
    int            kind;
    gbt_pkg::cmd_e cmd;
    logic [2:0]    row;
    logic [2:0]    col;
    logic [19:0]   weight;
    phase_vcount = '{15, 0, 8, 1, 2, 5, 4};
    phase_vcount[6] = $urandom_range(0, 15);

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = gbt_pkg::CmdClear;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed part ----
    // walks on the empty graph give the start vertex alone, marked last
    walk_from(gbt_pkg::CmdBfs, 3'd0);
    walk_from(gbt_pkg::CmdDfs, 3'd7);
    // weight extremes, non-edge weights, self loop, repeated and overlaid loads
    load_entry(3'd0, 3'd1, 20'd1);
    load_entry(3'd0, 3'd2, 20'hFFFFF);
    load_entry(3'd1, 3'd3, 20'd999999);
    load_entry(3'd2, 3'd3, 20'd1000001);
    load_entry(3'd3, 3'd3, 20'd5);          // self loop
    load_entry(3'd2, 3'd7, 20'd7);
    load_entry(3'd7, 3'd0, 20'd123);
    load_entry(3'd0, 3'd1, 20'd1);          // edge already there
    load_entry(3'd0, 3'd1, 20'd0);          // zero weight leaves the edge alone
    load_entry(3'd1, 3'd4, gbt_pkg::InfWeight);  // infinity is no edge
    walk_from(gbt_pkg::CmdBfs, 3'd0);
    walk_from(gbt_pkg::CmdDfs, 3'd0);
    walk_from(gbt_pkg::CmdDfs, 3'd3);
    walk_from(gbt_pkg::CmdBfs, 3'd6);       // isolated vertex
    wait_drained(SettleCycles);

    // shrink the vertex count: stored edges stay and are still walked
    write_vertex_count(4'd3);
    load_entry(3'd2, 3'd5, 20'd9);          // column out of range, dropped
    load_entry(3'd1, 3'd2, 20'd2);
    walk_from(gbt_pkg::CmdBfs, 3'd7);       // start beyond the vertex count
    send_item(gbt_pkg::CmdClear, 3'd0, 3'd0, 20'd0, 3'd0);
    walk_from(gbt_pkg::CmdDfs, 3'd0);
    wait_drained(SettleCycles);

    // ---- random part, one vertex_count setting per phase ----
    for (int ph = 0; ph < 7; ph++) begin
      write_vertex_count(4'(phase_vcount[ph]));
      // receiver holds off while items keep coming, so the block backs up
      if (ph == 2) hold_off_req = 1'b1;
      lim = (cur_vcount > gbt_pkg::VcountMax) ? gbt_pkg::MaxVertices : int'(cur_vcount);
      if ($urandom_range(0, 1) == 1)
        send_item(gbt_pkg::CmdClear, 3'($urandom), 3'($urandom), 20'($urandom),
                  3'($urandom));
      for (int n = 0; n < PhaseItems; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 3)       cmd = gbt_pkg::CmdClear;
        else if (pick < 58) cmd = gbt_pkg::CmdLoad;
        else if (pick < 79) cmd = gbt_pkg::CmdBfs;
        else                cmd = gbt_pkg::CmdDfs;
        // mostly entries inside the vertex count, a fifth anywhere
        if (lim == 0 || $urandom_range(0, 4) == 0) begin
          row = 3'($urandom_range(0, 7));
          col = 3'($urandom_range(0, 7));
        end else begin
          row = 3'($urandom_range(0, lim - 1));
          col = 3'($urandom_range(0, lim - 1));
        end
        kind = $urandom_range(0, 9);
        case (kind)
          0:       weight = 20'd0;
          1:       weight = gbt_pkg::InfWeight;
          2:       weight = 20'hFFFFF;
          3:       weight = 20'd1;
          default: weight = 20'($urandom_range(0, 20'hFFFFF));
        endcase
        send_item(cmd, row, col, weight, 3'($urandom_range(0, 7)));
      end
      wait_drained(SettleCycles);
    end

    // ---- end of run ----
    wait_drained(DrainCycles);
    $display("summary: %0d items sent, %0d walks, %0d visited vertices checked",
             items_sent, walk_count, visit_count);
    $display("summary: %0d vertex_count settings written, 0, 1, 8 and 15 among them",
             settings_written);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
